@@ rtl/fir_pkg.sv @@
// Shared constants, codes and types of the block FIR filter.
package fir_pkg;

	localparam int unsigned SAMPLE_W      = 24;
	localparam int unsigned COEF_W        = 24;
	localparam int unsigned OP_W          = 2;
	localparam int unsigned CIDX_W        = 8;
	localparam int unsigned TAPCNT_W      = 9;
	localparam int unsigned BLKLEN_W      = 13;
	localparam int unsigned CFG_W         = 13;
	localparam int unsigned CFG_IDX_W     = 2;
	localparam int unsigned MAX_TAPS_DEF  = 256;
	localparam int unsigned MAX_BLOCK_DEF = 4096;

	typedef enum logic [OP_W-1:0] {
		OP_SAMPLE = 2'd0,
		OP_COEF   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAPS   = 2'd0,
		REG_BLKLEN = 2'd1,
		REG_ENABLE = 2'd2,
		REG_SPARE  = 2'd3
	} reg_idx_t;

	// MAC pipeline control, aligned with the store read data
	typedef struct packed {
		logic clr;
		logic vld;
		logic last;
	} mac_ctl_t;

endpackage

@@ rtl/fir_store.sv @@
// Single-port-write, single-port-read store with per-entry valid bits.
module fir_store #(
	parameter int unsigned DEPTH = fir_pkg::MAX_TAPS_DEF,
	parameter int unsigned WIDTH = fir_pkg::SAMPLE_W,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             clr_all,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	import fir_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_q;
	logic             rd_vld_q;

	// unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr_all) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

@@ rtl/fir_mac.sv @@
// Multiply-accumulate pipeline with rounding and saturation of the sum.
module fir_mac #(
	parameter int unsigned MAX_TAPS = fir_pkg::MAX_TAPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fir_pkg::mac_ctl_t                   ctl,
	input  logic signed [fir_pkg::SAMPLE_W-1:0] hist,
	input  logic signed [fir_pkg::COEF_W-1:0]   coef,
	output logic                                res_valid,
	output logic signed [fir_pkg::SAMPLE_W-1:0] res
);
	import fir_pkg::*;

	localparam int unsigned PROD_W = SAMPLE_W + COEF_W;
	localparam int unsigned ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
	localparam int unsigned SH     = COEF_W - 2;
	localparam logic [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (SH - 1);
	localparam logic signed [SAMPLE_W-1:0] RES_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] RES_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1, last_s1, last_s2, done_s3, done_s4;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rnd_s3;
	logic signed [ACC_W-1:0]  shr;
	logic                     fits;
	logic signed [SAMPLE_W-1:0] sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			done_s3 <= 1'b0;
			done_s4 <= 1'b0;
		end else begin
			vld_s1  <= ctl.vld;
			last_s1 <= ctl.vld & ctl.last;
			last_s2 <= last_s1;
			done_s3 <= last_s2;
			done_s4 <= done_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= hist * coef;
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
		rnd_s3 <= acc_q + $signed(HALF);
		res    <= sat;
	end

	// floor shift, then clamp to the sample range
	always_comb begin
		shr  = rnd_s3 >>> SH;
		fits = (&shr[ACC_W-1:SAMPLE_W-1]) | ~(|shr[ACC_W-1:SAMPLE_W-1]);
		if (fits) begin
			sat = shr[SAMPLE_W-1:0];
		end else if (shr[ACC_W-1]) begin
			sat = RES_MIN;
		end else begin
			sat = RES_MAX;
		end
	end

	assign res_valid = done_s4;

endmodule

@@ rtl/block_fir_filter.sv @@
// Top level of the block FIR filter: sequencer, registers and output stage.
//
// Direct-form FIR filter over a circular history store and a coefficient
// store, each a synchronous memory with a registered read. The block
// works on one item at a time and holds in_stall high while busy. For a
// filtered sample, one shared multiplier walks the taps at one read of
// each store per cycle. Then come the last store read, a four-stage
// multiply/accumulate/round/saturate tail, the capture of the result and
// the load of the output register, which waits while an earlier result
// still stalls there. A sample that ends a call short of the block end
// then pushes zeros into the history, at most MAX_TAPS. A disabled
// (pass-through) sample goes straight to the output stage. A coefficient
// write waits in S_COEF, its index reduced by MAX_TAPS, until the index
// is below MAX_TAPS. A clear is taken without leaving idle. Reset and
// clear act at once on valid bits, so there is no clearing pass. The
// result waits in an output register, so the next item is taken while it is stalled.
module block_fir_filter #(
	parameter int unsigned MAX_TAPS  = fir_pkg::MAX_TAPS_DEF,
	parameter int unsigned MAX_BLOCK = fir_pkg::MAX_BLOCK_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [fir_pkg::OP_W-1:0]             op,
	input  logic signed [fir_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic                                 last_in_call,
	input  logic [fir_pkg::CIDX_W-1:0]           coef_index,
	input  logic signed [fir_pkg::COEF_W-1:0]    coef_value,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [fir_pkg::SAMPLE_W-1:0]  sample_out,
	// configuration writes
	input  logic                                 cfg_we,
	input  logic [fir_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fir_pkg::CFG_W-1:0]            cfg_data
);
	import fir_pkg::*;

	localparam int unsigned TAP_AW = $clog2(MAX_TAPS);
	localparam int unsigned TAP_CW = $clog2(MAX_TAPS + 1);
	localparam int unsigned POS_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_COEF = 6'b000010,
		S_MAC  = 6'b000100,
		S_WAIT = 6'b001000,
		S_OUT  = 6'b010000,
		S_PAD  = 6'b100000
	} state_t;

	state_t state_q;

	// configuration
	logic [TAPCNT_W-1:0] tap_count_q;
	logic [BLKLEN_W-1:0] block_length_q;
	logic                filter_enable_q;

	// filter state and sequencer counters
	logic [TAP_AW-1:0]   head_q;
	logic [POS_W-1:0]    pos_q;
	logic [TAP_CW-1:0]   j_q;
	logic [TAP_CW-1:0]   n_q;
	logic [TAP_CW-1:0]   pad_q;
	logic                rd_vld_q, rd_last_q;
	logic                out_valid_q;

	// payload
	logic signed [SAMPLE_W-1:0] res_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic [CIDX_W-1:0]          cidx_q;
	logic signed [COEF_W-1:0]   cval_q;

	logic        in_xfer, take_sample, take_coef, take_clear, take_pass;
	logic        out_free, mac_issue, mac_done;
	logic [TAP_AW-1:0] head_nx;
	logic [31:0] taps_use, blk_use, pos1, pad_raw;
	logic [31:0] pos_nx, pad_nx, hist_addr, cidx_ext;
	logic        cidx_big;
	mac_ctl_t    mac_ctl;

	logic                       hist_we;
	logic signed [SAMPLE_W-1:0] hist_wdata, hist_rdata;
	logic signed [COEF_W-1:0]   coef_rdata;
	logic signed [SAMPLE_W-1:0] mac_res;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid & ~in_stall;

	assign take_sample = in_xfer && (op_t'(op) == OP_SAMPLE) && filter_enable_q;
	assign take_pass   = in_xfer && (op_t'(op) == OP_SAMPLE) && !filter_enable_q;
	assign take_coef   = in_xfer && (op_t'(op) == OP_COEF);
	assign take_clear  = in_xfer && (op_t'(op) == OP_CLEAR);

	assign out_free  = ~out_valid_q | ~out_stall;
	assign mac_issue = (state_q == S_MAC);

	// next slot of the circular history
	assign head_nx = (head_q == TAP_AW'(MAX_TAPS - 1)) ? '0 : head_q + 1'b1;

	// register limits, block bookkeeping and the zero-padding length
	always_comb begin
		taps_use = 32'(tap_count_q);
		if (taps_use == 32'd0) begin
			taps_use = 32'd1;
		end else if (taps_use > MAX_TAPS) begin
			taps_use = MAX_TAPS;
		end
		blk_use = 32'(block_length_q);
		if (blk_use == 32'd0) begin
			blk_use = 32'd1;
		end else if (blk_use > MAX_BLOCK) begin
			blk_use = MAX_BLOCK;
		end
		pos1    = 32'(pos_q) + 32'd1;
		pad_raw = blk_use - pos1;
		pos_nx  = 32'd0;
		pad_nx  = 32'd0;
		if (pos1 >= blk_use) begin
			pos_nx = 32'd0;
		end else if (last_in_call) begin
			pad_nx = (pad_raw > MAX_TAPS) ? MAX_TAPS : pad_raw;
		end else begin
			pos_nx = pos1;
		end
	end

	// tap j reads the sample j places back from the newest
	always_comb begin
		if (32'(j_q) <= 32'(head_q)) begin
			hist_addr = 32'(head_q) - 32'(j_q);
		end else begin
			hist_addr = 32'(head_q) + MAX_TAPS - 32'(j_q);
		end
	end

	assign cidx_ext = 32'(cidx_q);
	assign cidx_big = (cidx_ext >= MAX_TAPS);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			tap_count_q     <= TAPCNT_W'(1);
			block_length_q  <= BLKLEN_W'(1);
			filter_enable_q <= 1'b0;
			head_q          <= '0;
			pos_q           <= '0;
			j_q             <= '0;
			n_q             <= TAP_CW'(1);
			pad_q           <= '0;
			rd_vld_q        <= 1'b0;
			rd_last_q       <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_TAPS:   tap_count_q     <= cfg_data[TAPCNT_W-1:0];
					REG_BLKLEN: block_length_q  <= cfg_data[BLKLEN_W-1:0];
					REG_ENABLE: filter_enable_q <= cfg_data[0];
					REG_SPARE:  ;
					default:    ;
				endcase
			end

			rd_vld_q  <= mac_issue;
			rd_last_q <= mac_issue && (j_q == n_q - 1'b1);

			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (take_sample) begin
						head_q  <= head_nx;
						pos_q   <= POS_W'(pos_nx);
						pad_q   <= TAP_CW'(pad_nx);
						n_q     <= TAP_CW'(taps_use);
						j_q     <= '0;
						state_q <= S_MAC;
					end else if (take_pass) begin
						pad_q   <= '0;
						state_q <= S_OUT;
					end else if (take_coef) begin
						state_q <= S_COEF;
					end else if (take_clear) begin
						head_q <= '0;
						pos_q  <= '0;
					end
				end
				S_COEF: begin
					if (!cidx_big) begin
						state_q <= S_IDLE;
					end
				end
				S_MAC: begin
					j_q <= j_q + 1'b1;
					if (j_q == n_q - 1'b1) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (mac_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= (pad_q != '0) ? S_PAD : S_IDLE;
					end
				end
				S_PAD: begin
					head_q <= head_nx;
					pad_q  <= pad_q - 1'b1;
					if (pad_q == TAP_CW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_pass) begin
			res_q <= sample_in;
		end else if (state_q == S_WAIT && mac_done) begin
			res_q <= mac_res;
		end
		if (state_q == S_OUT && out_free) begin
			sample_out_q <= res_q;
		end
		if (take_coef) begin
			cidx_q <= coef_index;
			cval_q <= coef_value;
		end else if (state_q == S_COEF && cidx_big) begin
			// index taken modulo the store depth
			cidx_q <= cidx_q - CIDX_W'(MAX_TAPS);
		end
	end

	// history: the new sample goes in on its transfer, pad zeros one a cycle
	assign hist_we    = take_sample | (state_q == S_PAD);
	assign hist_wdata = (state_q == S_PAD) ? '0 : sample_in;

	fir_store #(
		.DEPTH (MAX_TAPS),
		.WIDTH (SAMPLE_W)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (hist_we),
		.wr_addr (head_nx),
		.wr_data (hist_wdata),
		.clr_all (take_clear),
		.rd_en   (mac_issue),
		.rd_addr (TAP_AW'(hist_addr)),
		.rd_data (hist_rdata)
	);

	fir_store #(
		.DEPTH (MAX_TAPS),
		.WIDTH (COEF_W)
	) u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   ((state_q == S_COEF) && !cidx_big),
		.wr_addr (TAP_AW'(cidx_ext)),
		.wr_data (cval_q),
		.clr_all (1'b0),
		.rd_en   (mac_issue),
		.rd_addr (j_q[TAP_AW-1:0]),
		.rd_data (coef_rdata)
	);

	// accumulator is cleared on the sample transfer, before the first product
	assign mac_ctl.clr  = take_sample;
	assign mac_ctl.vld  = rd_vld_q;
	assign mac_ctl.last = rd_last_q;

	fir_mac #(
		.MAX_TAPS (MAX_TAPS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.hist      (hist_rdata),
		.coef      (coef_rdata),
		.res_valid (mac_done),
		.res       (mac_res)
	);

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

@@ rtl/fir_chk.sv @@
// Port-level checker for the block FIR filter, bound to the top level.
module fir_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic [fir_pkg::OP_W-1:0]             op,
	input logic signed [fir_pkg::SAMPLE_W-1:0]  sample_in,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic signed [fir_pkg::SAMPLE_W-1:0]  sample_out,
	input logic                                 cfg_we,
	input logic [fir_pkg::CFG_IDX_W-1:0]        cfg_index,
	input logic [fir_pkg::CFG_W-1:0]            cfg_data
);
	import fir_pkg::*;

	logic       en_q;
	logic [1:0] pend_q;
	logic       in_xfer, out_xfer, smp_xfer;

	assign in_xfer  = in_valid & ~in_stall;
	assign out_xfer = out_valid & ~out_stall;
	assign smp_xfer = in_xfer && (op == OP_SAMPLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b0;
			pend_q <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_ENABLE) begin
				en_q <= cfg_data[0];
			end
			pend_q <= pend_q + {1'b0, smp_xfer} - {1'b0, out_xfer};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out))
		else $error("stalled result changed or dropped");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (op == OP_SAMPLE || op == OP_COEF) |=> in_stall)
		else $error("input taken while a sample or coefficient is in work");

	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		smp_xfer && !en_q && !out_valid |=> ##1
			(out_valid && sample_out == $past(sample_in, 2)))
		else $error("pass-through sample not delivered unchanged");

	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q <= 2'd2) && (!out_valid || pend_q != 2'd0))
		else $error("result without a matching sample transfer");

endmodule

bind block_fir_filter fir_chk u_fir_chk (.*);

@@ tb/fir_checker.sv @@
// Checker for the block FIR filter: watches both channels, predicts each result and compares.
`timescale 1ns / 1ps

module fir_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic [fir_pkg::OP_W-1:0]             op,
	input  logic signed [fir_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic                                 last_in_call,
	input  logic [fir_pkg::CIDX_W-1:0]           coef_index,
	input  logic signed [fir_pkg::COEF_W-1:0]    coef_value,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [fir_pkg::SAMPLE_W-1:0]  sample_out,
	input  logic                                 cfg_we,
	input  logic [fir_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fir_pkg::CFG_W-1:0]            cfg_data,
	output int                                   fail_count,
	output int                                   pending,
	output int                                   results_checked
);
	import fir_pkg::*;

	localparam int unsigned TAPS      = MAX_TAPS_DEF;
	localparam int unsigned BLOCK     = MAX_BLOCK_DEF;
	localparam int unsigned RND_SHIFT = COEF_W - 2;
	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
	localparam int PRINT_CAP = 200;

	logic signed [SAMPLE_W-1:0] hist_mem [TAPS];
	logic signed [COEF_W-1:0]   coef_mem [TAPS];
	logic [CIDX_W-1:0]          hist_head;
	int unsigned                blk_pos;
	logic [TAPCNT_W-1:0]        taps_reg;
	logic [BLKLEN_W-1:0]        blklen_reg;
	logic                       enable_reg;
	logic [SAMPLE_W-1:0]        expected_out [$];
	int                         fails;
	int                         checked;

	task automatic report_mismatch(input string what);
		if (fails < PRINT_CAP)
			$display("%0t ns fir_checker: %s", $time, what);
		fails++;
	endtask

	function automatic void push_history(input logic [SAMPLE_W-1:0] x);
		hist_head = hist_head + 1'b1;
		hist_mem[hist_head] = x;
	endfunction

	// Sum of products over the taps in use, rounded half up and saturated
	function automatic logic [SAMPLE_W-1:0] fir_output();
		int unsigned n;
		logic [CIDX_W-1:0] slot;
		logic signed [63:0] acc;
		logic signed [63:0] term;
		logic signed [63:0] q;
		n = (taps_reg == 0) ? 1 : (taps_reg > TAPS) ? TAPS : 32'(taps_reg);
		acc = '0;
		for (int unsigned j = 0; j < n; j++) begin
			slot = hist_head - CIDX_W'(j);
			term = $signed({{(64 - COEF_W){coef_mem[j][COEF_W-1]}}, coef_mem[j]})
			     * $signed({{(64 - SAMPLE_W){hist_mem[slot][SAMPLE_W-1]}}, hist_mem[slot]});
			acc = acc + term;
		end
		q = (acc + (64'sd1 <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
		if (q > SAT_HI)
			q = SAT_HI;
		else if (q < SAT_LO)
			q = SAT_LO;
		return q[SAMPLE_W-1:0];
	endfunction

	task automatic predict_transfer(
		input logic [OP_W-1:0]     kind,
		input logic [SAMPLE_W-1:0] x,
		input logic                last,
		input logic [CIDX_W-1:0]   idx,
		input logic [COEF_W-1:0]   c
	);
		int unsigned blk;
		int unsigned next_pos;
		int unsigned zeros;
		case (kind)
			OP_COEF: coef_mem[idx] = c;
			OP_CLEAR: begin
				foreach (hist_mem[k])
					hist_mem[k] = '0;
				hist_head = '0;
				blk_pos   = 0;
			end
			OP_SAMPLE: begin
				if (!enable_reg) begin
					expected_out.push_back(x);
				end else begin
					blk = (blklen_reg == 0) ? 1 : (blklen_reg > BLOCK) ? BLOCK : 32'(blklen_reg);
					push_history(x);
					expected_out.push_back(fir_output());
					next_pos = blk_pos + 1;
					if (next_pos >= blk) begin
						next_pos = 0;
					end else if (last) begin
						// short call: zero-fill the rest of the block, only the newest TAPS count
						zeros = blk - next_pos;
						if (zeros > TAPS)
							zeros = TAPS;
						repeat (zeros) push_history('0);
						next_pos = 0;
					end
					blk_pos = next_pos;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (hist_mem[k]) begin
				hist_mem[k] = '0;
				coef_mem[k] = '0;
			end
			hist_head  = '0;
			blk_pos    = 0;
			taps_reg   = TAPCNT_W'(1);
			blklen_reg = BLKLEN_W'(1);
			enable_reg = 1'b0;
			expected_out.delete();
			fails   = 0;
			checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TAPS:   taps_reg   = cfg_data[TAPCNT_W-1:0];
					REG_BLKLEN: blklen_reg = cfg_data[BLKLEN_W-1:0];
					REG_ENABLE: enable_reg = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_out.size() == 0) begin
					report_mismatch($sformatf("result %0d with nothing predicted, sample_out %h",
						checked, sample_out));
				end else if (sample_out !== expected_out[0]) begin
					report_mismatch($sformatf("result %0d: sample_out %h, predicted %h",
						checked, sample_out, expected_out[0]));
					void'(expected_out.pop_front());
				end else begin
					void'(expected_out.pop_front());
				end
				checked++;
			end
			if (in_valid && !in_stall)
				predict_transfer(op, sample_in, last_in_call, coef_index, coef_value);
		end
		fail_count      <= fails;
		pending         <= expected_out.size();
		results_checked <= checked;
	end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the block FIR filter: clock, reset, stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module tb_top;
	import fir_pkg::*;

	// Longest legal quiet spell is the long receiver hold plus one full-length
	// sample with maximum zero padding; the limit sits well above that.
	localparam int STUCK_LIMIT   = 10000;
	// Covers 256 taps, the pipeline tail and 256 padding zeros after a result
	localparam int SETTLE_CYCLES = 600;
	localparam int LONG_HOLD     = 1500;
	localparam int NUM_SEGS      = 10;

	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       in_valid     = 1'b0;
	logic                       in_stall;
	logic [OP_W-1:0]            op           = OP_SAMPLE;
	logic signed [SAMPLE_W-1:0] sample_in    = '0;
	logic                       last_in_call = 1'b0;
	logic [CIDX_W-1:0]          coef_index   = '0;
	logic signed [COEF_W-1:0]   coef_value   = '0;
	logic                       out_valid;
	logic                       out_stall    = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index    = REG_TAPS;
	logic [CFG_W-1:0]           cfg_data     = '0;

	int fail_count;
	int pending;
	int results_checked;

	// Idle percentages for the current phase, read by the driver and the receiver
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	// Long receiver hold: the main thread asks, the receiver process counts it out
	int holds_asked  = 0;
	int holds_served = 0;
	int hold_left    = 0;
	int stuck_cycles = 0;

	int n_samples  = 0;
	int n_coefs    = 0;
	int n_clears   = 0;
	int n_ignored  = 0;
	int n_settings = 0;

	block_fir_filter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.sample_in    (sample_in),
		.last_in_call (last_in_call),
		.coef_index   (coef_index),
		.coef_value   (coef_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_out   (sample_out),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	fir_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.op              (op),
		.sample_in       (sample_in),
		.last_in_call    (last_in_call),
		.coef_index      (coef_index),
		.coef_value      (coef_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sample_out      (sample_out),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	always #1 clk = ~clk;

	// Receiver: random back-pressure per phase, or a long hold when asked.
	// During the hold the sender keeps offering, so the block backs up and
	// raises in_stall.
	always @(posedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served = holds_asked;
			hold_left    = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: any transfer on either channel restarts the count
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("tb_top: watchdog expired after %0d quiet cycles", stuck_cycles);
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// One input transfer. Entered just after a rising edge; valid stays high
	// straight into the next item when no idle cycle is drawn, so it is never
	// dropped and raised within one time step.
	task automatic send_item(
		input op_t                 kind,
		input logic [SAMPLE_W-1:0] smp,
		input logic                last,
		input logic [CIDX_W-1:0]   idx,
		input logic [COEF_W-1:0]   coef
	);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		op           <= kind;
		sample_in    <= smp;
		last_in_call <= last;
		coef_index   <= idx;
		coef_value   <= coef;
		do @(posedge clk); while (in_stall);
		case (kind)
			OP_SAMPLE: n_samples++;
			OP_COEF:   n_coefs++;
			OP_CLEAR:  n_clears++;
			default:   n_ignored++;
		endcase
	endtask

	// Sender pause: drop valid, wait for every predicted result, then let the
	// block finish any trailing zero fill before anything else happens.
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes every register, the spare index included; only called while idle
	task automatic configure(
		input logic [CFG_W-1:0] taps,
		input logic [CFG_W-1:0] blen,
		input logic [CFG_W-1:0] en,
		input logic [CFG_W-1:0] spare
	);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TAPS;
		cfg_data  <= taps;
		@(posedge clk);
		cfg_index <= REG_BLKLEN;
		cfg_data  <= blen;
		@(posedge clk);
		cfg_index <= REG_ENABLE;
		cfg_data  <= en;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data  <= spare;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// Mostly samples with random content, some coefficient updates aimed at
	// the live taps, the odd clear and the odd unused code.
	task automatic send_random_item(input int unsigned taps_eff, output bit counted);
		int unsigned pick;
		logic [31:0] r_smp;
		logic [31:0] r_coef;
		logic [SAMPLE_W-1:0] smp;
		logic [COEF_W-1:0] coef;
		logic [CIDX_W-1:0] idx;
		logic last;
		pick   = $urandom_range(99);
		r_smp  = $urandom;
		r_coef = $urandom;
		smp    = r_smp[SAMPLE_W-1:0];
		case (r_smp[27:24])
			4'd0: smp = 24'h7FFFFF;
			4'd1: smp = 24'h800000;
			default: ;
		endcase
		coef = r_coef[COEF_W-1:0];
		if (r_coef[31])
			coef = {{9{r_coef[14]}}, r_coef[14:0]};
		case (r_coef[28:26])
			3'd0: coef = 24'h7FFFFF;
			3'd1: coef = 24'h800000;
			default: ;
		endcase
		if (r_coef[30:29] == 2'd0)
			idx = CIDX_W'($urandom_range(255));
		else
			idx = CIDX_W'($urandom_range(taps_eff - 1));
		last    = ($urandom_range(7) == 0);
		counted = 1'b1;
		if (pick < 2) begin
			send_item(OP_NONE, smp, last, idx, coef);
			counted = 1'b0;
		end else if (pick < 4) begin
			send_item(OP_CLEAR, smp, last, idx, coef);
		end else if (pick < 14) begin
			send_item(OP_COEF, smp, last, idx, coef);
		end else begin
			send_item(OP_SAMPLE, smp, last, idx, coef);
		end
	endtask

	initial begin
		int unsigned taps_eff;
		int unsigned tap_bits;
		int items;
		int done;
		logic [CFG_W-1:0] t_reg;
		logic [CFG_W-1:0] b_reg;
		logic [CFG_W-1:0] e_reg;
		bit counted;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: pass-through at reset settings, then a four-tap filter
		// over three-sample blocks to hit saturation both ways, a full block,
		// a short call, a clear, an out-of-range tap index and the unused code.
		send_item(OP_SAMPLE, 24'h7FFFFF, 1'b0, 8'h00, 24'h000000);
		send_item(OP_SAMPLE, 24'h800000, 1'b1, 8'h00, 24'h000000);
		send_item(OP_NONE,   24'hFFFFFF, 1'b1, 8'hFF, 24'hFFFFFF);
		drain_and_settle();
		configure(13'd4, 13'd3, 13'd1, 13'h1FFF);
		send_item(OP_COEF,   24'h000000, 1'b0, 8'd0,  24'h7FFFFF);
		send_item(OP_COEF,   24'h000000, 1'b0, 8'd1,  24'h7FFFFF);
		send_item(OP_COEF,   24'h000000, 1'b0, 8'd2,  24'h800000);
		send_item(OP_COEF,   24'h000000, 1'b0, 8'd3,  24'h400000);
		send_item(OP_COEF,   24'h000000, 1'b0, 8'hFF, 24'h123456);
		send_item(OP_SAMPLE, 24'h7FFFFF, 1'b0, 8'h00, 24'h000000);
		send_item(OP_SAMPLE, 24'h7FFFFF, 1'b0, 8'h00, 24'h000000);
		send_item(OP_SAMPLE, 24'h7FFFFF, 1'b0, 8'h00, 24'h000000);
		send_item(OP_SAMPLE, 24'h800000, 1'b1, 8'h00, 24'h000000);
		send_item(OP_SAMPLE, 24'h000001, 1'b0, 8'h00, 24'h000000);
		send_item(OP_CLEAR,  24'h000000, 1'b0, 8'h00, 24'h000000);
		send_item(OP_SAMPLE, 24'h800000, 1'b0, 8'h00, 24'h000000);
		send_item(OP_SAMPLE, 24'h400000, 1'b1, 8'h00, 24'h000000);
		send_item(OP_NONE,   24'h000000, 1'b0, 8'h00, 24'h000000);
		send_item(OP_COEF,   24'h000000, 1'b0, 8'd0,  24'h000001);
		send_item(OP_SAMPLE, 24'h000001, 1'b0, 8'h00, 24'h000000);
		send_item(OP_SAMPLE, 24'hFFFFFF, 1'b0, 8'h00, 24'h000000);

		// Random phases. Extremes of the registers first, out-of-range codes
		// and upper data bits included; the largest sizes get few items.
		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			drain_and_settle();
			case (seg)
				0: begin t_reg = 13'd1;    b_reg = 13'd1;    e_reg = 13'd1;    items = 150; end
				1: begin t_reg = 13'd256;  b_reg = 13'd4096; e_reg = 13'd1;    items = 40;  end
				2: begin t_reg = 13'h1200; b_reg = 13'd0;    e_reg = 13'd1;    items = 100; end
				3: begin t_reg = 13'd511;  b_reg = 13'd8191; e_reg = 13'd1;    items = 30;  end
				4: begin
					t_reg = CFG_W'($urandom_range(2, 32));
					b_reg = CFG_W'($urandom_range(1, 64));
					e_reg = 13'h1FFE;
					items = 100;
				end
				default: begin
					t_reg = CFG_W'($urandom_range(2, 32));
					b_reg = CFG_W'($urandom_range(1, 64));
					e_reg = 13'd1;
					items = 136;
				end
			endcase
			case (seg % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			configure(t_reg, b_reg, e_reg, CFG_W'($urandom));
			tap_bits = t_reg[TAPCNT_W-1:0];
			taps_eff = (tap_bits == 0) ? 1 : (tap_bits > MAX_TAPS_DEF) ? MAX_TAPS_DEF : tap_bits;
			done = 0;
			while (done < items) begin
				if (seg == 8 && done == 20)
					holds_asked++;
				send_random_item(taps_eff, counted);
				if (counted)
					done++;
			end
		end
		drain_and_settle();

		$display("tb_top: %0d samples, %0d coefficient writes, %0d clears, %0d unused codes over %0d register settings",
			n_samples, n_coefs, n_clears, n_ignored, n_settings);
		$display("tb_top: %0d results compared, %0d mismatches", results_checked, fail_count);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
